// ----- hw/rtl/dgr_pkg.sv -----
package dgr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 22;

    localparam int DIV_N = 26 + FRAC_BITS;
    localparam int DIV_D = 30;
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 31;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_POS_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_POS_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_PLANE_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_PLANE_Y = 3'd7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic        operation;
        logic [11:0] column;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [7:0]  cell_value;
    } in_t;

    typedef struct packed {
        logic [11:0] stripe_top;
        logic [11:0] stripe_bottom;
        logic        wall_side;
        logic [5:0]  hit_x;
        logic [5:0]  hit_y;
        logic [23:0] wall_distance;
        logic        left_map;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- hw/rtl/dgr_div.sv -----
module dgr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  dgr_pkg::div_req_t req,
    output dgr_pkg::div_rsp_t rsp
);
    import dgr_pkg::*;

    localparam int CNT_W = $clog2(DIV_N);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [DIV_N-1:0] quo_reg;
    logic [DIV_D-1:0] rem_reg;
    logic [DIV_D-1:0] dvs_reg;
    logic [DIV_D:0]   shifted;
    logic [DIV_D:0]   diff;
    logic             fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[DIV_N-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DIV_N - 1);
            end else if (busy_reg) begin
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_N-2:0], fits};
            rem_reg <= fits ? diff[DIV_D-1:0] : shifted[DIV_D-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- hw/rtl/dgr_mul.sv -----
module dgr_mul (
    input  logic                                aclk,
    input  logic signed [dgr_pkg::MUL_A_W-1:0]  a,
    input  logic signed [dgr_pkg::MUL_B_W-1:0]  b,
    output logic signed [dgr_pkg::MUL_P_W-1:0]  p
);
    import dgr_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/dgr_map.sv -----
module dgr_map #(
    parameter int MAP_DIM   = 64,
    parameter int CELL_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  wr_en,
    input  logic [$clog2(MAP_DIM*MAP_DIM)-1:0]    wr_addr,
    input  logic [CELL_BITS-1:0]                  wr_data,
    input  logic [$clog2(MAP_DIM*MAP_DIM)-1:0]    rd_addr,
    output logic [CELL_BITS-1:0]                  rd_data,
    output logic                                  clear_busy
);
    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int AW = $clog2(DEPTH);

    logic [CELL_BITS-1:0] mem [DEPTH];
    logic [CELL_BITS-1:0] rd_data_reg;
    logic                 clr_busy_reg;
    logic [AW-1:0]        clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ----- hw/rtl/dda_grid_raycast_column.sv -----
// Write transaction: stores the cell value, no result.
// Cast transaction: walks the grid for at most 2 * MAP_DIM + 4 steps; a ray that leaves the grid
// skips the distance and line-height divisions.
// One transaction is in work at a time; a finished result waits in the output register.
// After reset the map is cleared one cell per cycle (MAP_DIM * MAP_DIM cells), s_ready low.
// Configuration registers return to their defaults at reset.
module dda_grid_raycast_column #(
    parameter int MAP_DIM   = 64,
    parameter int CELL_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  dgr_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dgr_pkg::out_t                     m_data,
    input  logic                              cfg_we,
    input  logic [dgr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dgr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dgr_pkg::*;

    localparam int AW = $clog2(MAP_DIM * MAP_DIM);
    localparam int CW = $clog2(MAP_DIM) + 2;
    localparam int ITER_LIMIT = 2 * MAP_DIM + 4;
    localparam int IW = $clog2(ITER_LIMIT + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_CAM, S_CAM_W, S_RAYX, S_RAYY, S_FX, S_FY, S_FZ, S_INIT,
        S_STEP, S_CHECK, S_DIST, S_DIST_W, S_LINE, S_LINE_W, S_RES, S_OUT
    } state_t;

    logic [12:0]        width_reg, height_reg;
    logic [21:0]        pos_x_reg, pos_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    state_t             state_reg, state_next;
    logic [11:0]        col_reg, col_next;
    logic signed [30:0] cam_reg, cam_next;
    logic signed [30:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [55:0]        lhs_reg, lhs_next, rhs_reg, rhs_next;
    logic signed [CW-1:0] mx_reg, mx_next, my_reg, my_next;
    logic               side_reg, side_next;
    logic [IW-1:0]      iter_reg, iter_next;
    logic [23:0]        dist_reg, dist_next;
    logic [31:0]        line_reg, line_next;
    out_t               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic [12:0]        w_eff, h_eff;
    logic [29:0]        arx, ary;
    logic [16:0]        fx, fy;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               map_wr_en;
    logic [AW-1:0]      map_wr_addr;
    logic [AW-1:0]      map_rd_addr;
    logic [CELL_BITS-1:0] map_rd_data;
    logic               map_busy;

    logic               take_x;
    logic signed [CW-1:0] step_mx, step_my;
    logic               step_out;
    logic signed [CW-1:0] edge_c;
    logic signed [26:0] edge_fx, num;
    logic [25:0]        num_mag;
    logic [29:0]        dist_dvs;
    logic [11:0]        half_h;
    logic [30:0]        half_line;
    logic [31:0]        de_sum;
    logic [12:0]        h_m1, de_val;
    logic [11:0]        ds_val;

    function automatic logic signed [30:0] ray_sat(input logic signed [MUL_P_W-1:0] p,
                                                   input logic signed [17:0] d);
        logic signed [33:0] s;
        s = 34'(p >>> FRAC_BITS) + 34'(d);
        if (s > 34'sd1073741823) begin
            ray_sat = 31'sd1073741823;
        end else if (s < -34'sd1073741823) begin
            ray_sat = -31'sd1073741823;
        end else begin
            ray_sat = 31'(s);
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 13'd640;
            height_reg  <= 13'd480;
            pos_x_reg   <= 22'd98304;
            pos_y_reg   <= 22'd98304;
            dir_x_reg   <= -18'sd65536;
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= 18'sd43254;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:   width_reg   <= cfg_data[12:0];
                REG_SCREEN_HEIGHT:  height_reg  <= cfg_data[12:0];
                REG_CAMERA_POS_X:   pos_x_reg   <= cfg_data;
                REG_CAMERA_POS_Y:   pos_y_reg   <= cfg_data;
                REG_VIEW_DIR_X:     dir_x_reg   <= signed'(cfg_data[17:0]);
                REG_VIEW_DIR_Y:     dir_y_reg   <= signed'(cfg_data[17:0]);
                REG_CAMERA_PLANE_X: plane_x_reg <= signed'(cfg_data[17:0]);
                REG_CAMERA_PLANE_Y: plane_y_reg <= signed'(cfg_data[17:0]);
                default: ;
            endcase
        end
    end

    dgr_map #(.MAP_DIM(MAP_DIM), .CELL_BITS(CELL_BITS)) u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (map_wr_en),
        .wr_addr    (map_wr_addr),
        .wr_data    (CELL_BITS'(s_data.cell_value)),
        .rd_addr    (map_rd_addr),
        .rd_data    (map_rd_data),
        .clear_busy (map_busy)
    );

    dgr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    dgr_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign s_ready = (state_reg == S_IDLE) && !map_busy;
    assign map_wr_en = s_valid && s_ready && (s_data.operation == OP_WRITE)
                       && (int'(s_data.cell_x) < MAP_DIM) && (int'(s_data.cell_y) < MAP_DIM);
    assign map_wr_addr = AW'(int'(s_data.cell_x) * MAP_DIM + int'(s_data.cell_y));

    always_comb begin
        w_eff = (width_reg == '0) ? 13'd1 : width_reg;
        h_eff = (height_reg == '0) ? 13'd1 : height_reg;
        arx = rx_reg[30] ? 30'(-rx_reg) : rx_reg[29:0];
        ary = ry_reg[30] ? 30'(-ry_reg) : ry_reg[29:0];
        fx = rx_reg[30] ? {1'b0, pos_x_reg[15:0]} : 17'h10000 - {1'b0, pos_x_reg[15:0]};
        fy = ry_reg[30] ? {1'b0, pos_y_reg[15:0]} : 17'h10000 - {1'b0, pos_y_reg[15:0]};

        take_x = lhs_reg < rhs_reg;
        step_mx = mx_reg;
        step_my = my_reg;
        if (take_x) begin
            step_mx = rx_reg[30] ? mx_reg - CW'(1) : mx_reg + CW'(1);
        end else begin
            step_my = ry_reg[30] ? my_reg - CW'(1) : my_reg + CW'(1);
        end
        step_out = (step_mx < 0) || (int'(step_mx) >= MAP_DIM)
                   || (step_my < 0) || (int'(step_my) >= MAP_DIM);
        map_rd_addr = AW'(int'(step_mx) * MAP_DIM + int'(step_my));

        edge_c = side_reg ? my_reg + $signed({{(CW-1){1'b0}}, ry_reg[30]})
                          : mx_reg + $signed({{(CW-1){1'b0}}, rx_reg[30]});
        edge_fx = 27'(edge_c) <<< FRAC_BITS;
        num = edge_fx - $signed(27'(side_reg ? pos_y_reg : pos_x_reg));
        num_mag = num[26] ? 26'(-num) : num[25:0];
        dist_dvs = side_reg ? ary : arx;

        half_h = h_eff[12:1];
        half_line = line_reg[31:1];
        h_m1 = h_eff - 13'd1;
        ds_val = (half_line > 31'(half_h)) ? 12'd0 : half_h - half_line[11:0];
        de_sum = 32'(half_line) + 32'(half_h);
        de_val = (de_sum > 32'(h_m1)) ? h_m1 : de_sum[12:0];
        if (de_val > 13'd4095) begin
            de_val = 13'd4095;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RAYX: begin
                mul_a = plane_x_reg;
                mul_b = cam_reg;
            end
            S_RAYY: begin
                mul_a = plane_y_reg;
                mul_b = cam_reg;
            end
            S_FY: begin
                mul_a = $signed({1'b0, fy});
                mul_b = $signed({1'b0, arx});
            end
            S_FZ: begin
                mul_a = $signed({1'b0, fx});
                mul_b = $signed({1'b0, ary});
            end
            default: ;
        endcase
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.dividend = '0;
        div_req.divisor = '0;
        case (state_reg)
            S_CAM: begin
                div_req.start = 1'b1;
                div_req.dividend = DIV_N'(col_reg) << (FRAC_BITS + 1);
                div_req.divisor = DIV_D'(w_eff);
            end
            S_DIST: begin
                div_req.start = dist_dvs != '0;
                div_req.dividend = DIV_N'(num_mag) << FRAC_BITS;
                div_req.divisor = dist_dvs;
            end
            S_LINE: begin
                div_req.start = dist_reg != '0;
                div_req.dividend = DIV_N'(h_eff) << FRAC_BITS;
                div_req.divisor = DIV_D'(dist_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        col_next = col_reg;
        cam_next = cam_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        lhs_next = lhs_reg;
        rhs_next = rhs_reg;
        mx_next = mx_reg;
        my_next = my_reg;
        side_next = side_reg;
        iter_next = iter_reg;
        dist_next = dist_reg;
        line_next = line_reg;
        res_next = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready && (s_data.operation == OP_CAST)) begin
                    col_next = s_data.column;
                    state_next = S_CAM;
                end
            end
            S_CAM: state_next = S_CAM_W;
            S_CAM_W: begin
                if (div_rsp.done) begin
                    cam_next = signed'(31'(div_rsp.quotient[29:0])) - 31'sd65536;
                    state_next = S_RAYX;
                end
            end
            S_RAYX: state_next = S_RAYY;
            S_RAYY: begin
                rx_next = ray_sat(mul_p, dir_x_reg);
                state_next = S_FX;
            end
            S_FX: begin
                ry_next = ray_sat(mul_p, dir_y_reg);
                state_next = S_FY;
            end
            S_FY: state_next = S_FZ;
            S_FZ: begin
                rhs_next = 56'(mul_p);
                state_next = S_INIT;
            end
            S_INIT: begin
                lhs_next = 56'(mul_p);
                mx_next = CW'(pos_x_reg[21:16]);
                my_next = CW'(pos_y_reg[21:16]);
                side_next = 1'b0;
                iter_next = '0;
                if ((int'(pos_x_reg[21:16]) < MAP_DIM) && (int'(pos_y_reg[21:16]) < MAP_DIM)) begin
                    state_next = S_STEP;
                end else begin
                    res_next = '0;
                    res_next.wall_distance = DIST_MAX;
                    res_next.left_map = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_STEP: begin
                if (take_x) begin
                    lhs_next = lhs_reg + (56'(ary) << FRAC_BITS);
                end else begin
                    rhs_next = rhs_reg + (56'(arx) << FRAC_BITS);
                end
                side_next = !take_x;
                mx_next = step_mx;
                my_next = step_my;
                iter_next = iter_reg + IW'(1);
                if (step_out) begin
                    res_next = '0;
                    res_next.wall_distance = DIST_MAX;
                    res_next.left_map = 1'b1;
                    state_next = S_OUT;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (map_rd_data != '0) begin
                    state_next = S_DIST;
                end else if (iter_reg == IW'(ITER_LIMIT)) begin
                    res_next = '0;
                    res_next.wall_distance = DIST_MAX;
                    res_next.left_map = 1'b1;
                    state_next = S_OUT;
                end else begin
                    state_next = S_STEP;
                end
            end
            S_DIST: begin
                if (dist_dvs == '0) begin
                    dist_next = DIST_MAX;
                    state_next = S_LINE;
                end else begin
                    state_next = S_DIST_W;
                end
            end
            S_DIST_W: begin
                if (div_rsp.done) begin
                    dist_next = (div_rsp.quotient[DIV_N-1:24] != '0) ? DIST_MAX
                                                                   : div_rsp.quotient[23:0];
                    state_next = S_LINE;
                end
            end
            S_LINE: begin
                if (dist_reg == '0) begin
                    line_next = '1;
                    state_next = S_RES;
                end else begin
                    state_next = S_LINE_W;
                end
            end
            S_LINE_W: begin
                if (div_rsp.done) begin
                    line_next = div_rsp.quotient[31:0];
                    state_next = S_RES;
                end
            end
            S_RES: begin
                res_next.stripe_top = ds_val;
                res_next.stripe_bottom = de_val[11:0];
                res_next.wall_side = side_reg;
                res_next.hit_x = 6'(mx_reg);
                res_next.hit_y = 6'(my_reg);
                res_next.wall_distance = dist_reg;
                res_next.left_map = 1'b0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        col_reg    <= col_next;
        cam_reg    <= cam_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        side_reg   <= side_next;
        iter_reg   <= iter_next;
        dist_reg   <= dist_next;
        line_reg   <= line_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import dgr_pkg::*;

    localparam int MAP_N = 64;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int N_RANDOM = 1480;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #10 aclk = ~aclk;

    dda_grid_raycast_column u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [21:0] regs_q [8];
    logic [7:0] grid_q [MAP_N*MAP_N];
    out_t column_queue [$];
    int errors = 0;
    int casts_sent = 0;
    int writes_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;

    function automatic longint floor_shift(longint v);
        if (v >= 0) return v >>> FRAC_BITS;
        return -((-(v + 1)) >>> FRAC_BITS) - 1;
    endfunction

    function automatic longint clamp_ray(longint v);
        longint lim;
        lim = (longint'(1) << 30) - 1;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic out_t cast_column(logic [11:0] col);
        out_t r;
        longint w, h, px, py, cam, rx, ry, arx, ary, fx, fy, mx, my, sx, sy;
        longint kx, ky, num, edge_v, dist_v, line_h, ds, de, lhs, rhs;
        bit side, hit;
        w = regs_q[REG_SCREEN_WIDTH] != 0 ? longint'(regs_q[REG_SCREEN_WIDTH][12:0]) : 1;
        h = regs_q[REG_SCREEN_HEIGHT] != 0 ? longint'(regs_q[REG_SCREEN_HEIGHT][12:0]) : 1;
        px = longint'(regs_q[REG_CAMERA_POS_X]);
        py = longint'(regs_q[REG_CAMERA_POS_Y]);
        cam = (2 * longint'(col) * ONE) / w - ONE;
        rx = clamp_ray(longint'($signed(regs_q[REG_VIEW_DIR_X][17:0]))
            + floor_shift(longint'($signed(regs_q[REG_CAMERA_PLANE_X][17:0])) * cam));
        ry = clamp_ray(longint'($signed(regs_q[REG_VIEW_DIR_Y][17:0]))
            + floor_shift(longint'($signed(regs_q[REG_CAMERA_PLANE_Y][17:0])) * cam));
        arx = rx < 0 ? -rx : rx;
        ary = ry < 0 ? -ry : ry;
        mx = px >> FRAC_BITS;
        my = py >> FRAC_BITS;
        sx = rx < 0 ? -1 : 1;
        sy = ry < 0 ? -1 : 1;
        fx = rx < 0 ? (px % ONE) : ONE - (px % ONE);
        fy = ry < 0 ? (py % ONE) : ONE - (py % ONE);
        kx = 0;
        ky = 0;
        side = 1'b0;
        hit = 1'b0;
        r = '0;
        if (mx < MAP_N && my < MAP_N) begin
            for (int i = 0; i < 2 * MAP_N + 4; i++) begin
                lhs = (fx + kx * ONE) * ary;
                rhs = (fy + ky * ONE) * arx;
                if (lhs < rhs) begin
                    kx++; mx += sx; side = 1'b0;
                end else begin
                    ky++; my += sy; side = 1'b1;
                end
                if (mx < 0 || mx >= MAP_N || my < 0 || my >= MAP_N) break;
                if (grid_q[mx * MAP_N + my] != 0) begin
                    hit = 1'b1;
                    break;
                end
            end
        end
        if (!hit) begin
            r.wall_distance = DIST_MAX;
            r.left_map = 1'b1;
            return r;
        end
        if (!side) begin
            edge_v = mx + (sx < 0 ? 1 : 0);
            num = edge_v * ONE - px;
            if (num < 0) num = -num;
            dist_v = arx != 0 ? (num * ONE) / arx : longint'(DIST_MAX);
        end else begin
            edge_v = my + (sy < 0 ? 1 : 0);
            num = edge_v * ONE - py;
            if (num < 0) num = -num;
            dist_v = ary != 0 ? (num * ONE) / ary : longint'(DIST_MAX);
        end
        if (dist_v > longint'(DIST_MAX)) dist_v = longint'(DIST_MAX);
        line_h = dist_v != 0 ? (h * ONE) / dist_v : 64'hFFFFFFFF;
        ds = h / 2 - line_h / 2;
        if (ds < 0) ds = 0;
        de = line_h / 2 + h / 2;
        if (de > h - 1) de = h - 1;
        if (ds > 4095) ds = 4095;
        if (de > 4095) de = 4095;
        r.stripe_top = ds[11:0];
        r.stripe_bottom = de[11:0];
        r.wall_side = side;
        r.hit_x = mx[5:0];
        r.hit_y = my[5:0];
        r.wall_distance = dist_v[23:0];
        return r;
    endfunction

    task automatic reset_model();
        regs_q[0] = 640; regs_q[1] = 480; regs_q[2] = 98304; regs_q[3] = 98304;
        regs_q[4] = 22'h30000; regs_q[5] = 0; regs_q[6] = 0; regs_q[7] = 43254;
        foreach (grid_q[i]) grid_q[i] = '0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        logic [21:0] mask;
        mask = (idx <= REG_SCREEN_HEIGHT) ? 22'h1FFF
             : (idx <= REG_CAMERA_POS_Y) ? 22'h3FFFFF : 22'h3FFFF;
        s_valid <= 1'b0;
        while (column_queue.size() != 0) @(negedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        regs_q[idx] = CFG_DATA_W'(val) & mask;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Every transaction is sent with valid held until the handshake completes.
    task automatic send_item(in_t item, bit typed, out_t typed_res);
        out_t res;
        while (!no_idle && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (item.operation == OP_WRITE) begin
            grid_q[item.cell_x * MAP_N + item.cell_y] = item.cell_value;
            writes_sent++;
        end else begin
            res = typed ? typed_res : cast_column(item.column);
            column_queue.push_back(res);
            casts_sent++;
        end
        @(negedge aclk);
    endtask

    function automatic in_t make_write(int x, int y, int v);
        in_t t;
        t = '0;
        t.operation = OP_WRITE;
        t.cell_x = 6'(x);
        t.cell_y = 6'(y);
        t.cell_value = 8'(v);
        return t;
    endfunction

    function automatic in_t make_cast(int col);
        in_t t;
        t = in_t'(33'({$urandom, $urandom}));
        t.operation = OP_CAST;
        t.column = 12'(col);
        return t;
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        while (column_queue.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= no_idle || ($urandom_range(99) >= 21);
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (column_queue.size() == 0) begin
                $error("result with no cast pending");
                errors++;
            end else begin
                want = column_queue.pop_front();
                if (!m_data.left_map) hits_seen++;
                if (m_data.stripe_top !== want.stripe_top) begin
                    $error("stripe_top: expected %0d, got %0d", want.stripe_top, m_data.stripe_top);
                    errors++;
                end
                if (m_data.stripe_bottom !== want.stripe_bottom) begin
                    $error("stripe_bottom: expected %0d, got %0d",
                        want.stripe_bottom, m_data.stripe_bottom);
                    errors++;
                end
                if (m_data.wall_side !== want.wall_side) begin
                    $error("wall_side: expected %0d, got %0d", want.wall_side, m_data.wall_side);
                    errors++;
                end
                if (m_data.hit_x !== want.hit_x) begin
                    $error("hit_x: expected %0d, got %0d", want.hit_x, m_data.hit_x);
                    errors++;
                end
                if (m_data.hit_y !== want.hit_y) begin
                    $error("hit_y: expected %0d, got %0d", want.hit_y, m_data.hit_y);
                    errors++;
                end
                if (m_data.wall_distance !== want.wall_distance) begin
                    $error("wall_distance: expected %0d, got %0d",
                        want.wall_distance, m_data.wall_distance);
                    errors++;
                end
                if (m_data.left_map !== want.left_map) begin
                    $error("left_map: expected %0d, got %0d", want.left_map, m_data.left_map);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** dda_grid_raycast_column: FAILED **");
                $finish;
            end
        end
    end

    typedef struct {
        in_t item;
        bit typed;
        out_t res;
    } stim_row_t;

    out_t leave_res;
    stim_row_t directed [$];

    task automatic set_view(int pxv, int pyv, int dx, int dy, int plx, int ply);
        write_reg(REG_CAMERA_POS_X, pxv);
        write_reg(REG_CAMERA_POS_Y, pyv);
        write_reg(REG_VIEW_DIR_X, dx);
        write_reg(REG_VIEW_DIR_Y, dy);
        write_reg(REG_CAMERA_PLANE_X, plx);
        write_reg(REG_CAMERA_PLANE_Y, ply);
    endtask

    initial begin
        int n;
        int x, y;
        leave_res = '0;
        leave_res.wall_distance = DIST_MAX;
        leave_res.left_map = 1'b1;
        reset_model();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Empty map after reset: every ray leaves the grid; then border walls are written and cast against.
        directed.push_back('{make_cast(0), 1'b1, leave_res});
        directed.push_back('{make_cast(4095), 1'b1, leave_res});
        directed.push_back('{make_cast(320), 1'b1, leave_res});
        for (int i = 0; i < MAP_N; i++) begin
            directed.push_back('{make_write(i, 0, 1), 1'b0, leave_res});
            directed.push_back('{make_write(i, 63, 255), 1'b0, leave_res});
            directed.push_back('{make_write(0, i, 128), 1'b0, leave_res});
            directed.push_back('{make_write(63, i, 2), 1'b0, leave_res});
        end
        directed.push_back('{make_write(1, 1, 0), 1'b0, leave_res});
        directed.push_back('{make_write(3, 1, 7), 1'b0, leave_res});
        directed.push_back('{make_cast(0), 1'b0, leave_res});
        directed.push_back('{make_cast(639), 1'b0, leave_res});
        directed.push_back('{make_cast(320), 1'b0, leave_res});
        directed.push_back('{make_cast(4095), 1'b0, leave_res});
        foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].res);
        drain();

        // Register extremes, including zero size, zero ray parts and a start in the far corner cell.
        write_reg(REG_SCREEN_WIDTH, 0);
        write_reg(REG_SCREEN_HEIGHT, 0);
        set_view(22'h3FFFFF, 22'h3FFFFF, 0, 0, 0, 0);
        send_item(make_cast(5), 1'b1, leave_res);
        set_view(32 * ONE, 32 * ONE, 131071, 0, 0, 0);
        send_item(make_cast(0), 1'b0, leave_res);
        write_reg(REG_SCREEN_WIDTH, 4096);
        write_reg(REG_SCREEN_HEIGHT, 4096);
        set_view(62 * ONE + 1, ONE, 18'h20000, 0, 18'h1FFFF, 18'h20000);
        send_item(make_cast(0), 1'b0, leave_res);
        send_item(make_cast(4095), 1'b0, leave_res);
        set_view(ONE, 0, 0, 0, 0, 0);
        send_item(make_cast(2048), 1'b0, leave_res);
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            write_reg(REG_SCREEN_WIDTH, phase == 0 ? 1 : $urandom_range(1, 4096));
            write_reg(REG_SCREEN_HEIGHT, phase == 1 ? 1 : $urandom_range(1, 4096));
            if (phase == 2) begin
                set_view(1, 22'h3FFFFF, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000);
            end else begin
                set_view($urandom_range(2 * ONE, 62 * ONE - 1), $urandom_range(2 * ONE, 62 * ONE - 1),
                    $urandom, $urandom, $urandom, $urandom);
            end
            no_idle = (phase == 3);
            n = 0;
            while (n < N_RANDOM / 7) begin
                if ($urandom_range(99) < 45) begin
                    x = $urandom_range(63);
                    y = $urandom_range(63);
                    send_item(make_write(x, y, $urandom_range(99) < 35 ? 0 : $urandom_range(1, 255)),
                        1'b0, leave_res);
                end else begin
                    send_item(make_cast($urandom_range(99) < 80
                        ? $urandom_range(regs_q[REG_SCREEN_WIDTH] > 0
                            ? regs_q[REG_SCREEN_WIDTH] - 1 : 0) : $urandom_range(4095)),
                        1'b0, leave_res);
                end
                n++;
            end
            drain();
        end
        no_idle = 1'b0;

        $display("Sent %0d casts and %0d map writes over several view settings.",
            casts_sent, writes_sent);
        $display("Checked %0d results, %0d of them wall hits.", results_seen, hits_seen);
        if (errors == 0 && column_queue.size() == 0) begin
            $display("** dda_grid_raycast_column: PASSED **");
        end else begin
            $display("** dda_grid_raycast_column: FAILED **");
        end
        $finish;
    end

endmodule
